FILE: rtl/stb_pkg.sv
// Shared types and constants for the software timer bank.
// Request codes, sequencer states and result limits; no dependencies.
`default_nettype none

package stb_pkg;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_ALLOC = 3'd1;
   localparam logic [2:0] REQ_SET   = 3'd2;
   localparam logic [2:0] REQ_START = 3'd3;
   localparam logic [2:0] REQ_STOP  = 3'd4;
   localparam logic [2:0] REQ_RESET = 3'd5;

   localparam int MAX_RESULTS = 8;
   localparam int HIT_AW      = 3;
   localparam int HIT_CW      = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK_RD,
      ST_WALK_UPD,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/software_timer_bank.sv
// Software timer bank top level: request decoder, tick walker and result register.
// Depends on stb_pkg for request codes, states and result limits.
//
// Usage:
//   The req_ channel carries one request per transfer (tick, allocate, set,
//   start, stop, reset). The block takes a request only while its sequencer is
//   idle; req_stall stays high while a request is in progress.
//   Every request gives one or more transfers on the rsp_ channel; the last
//   one of a request has rsp_last_result set.
//   Allocate, set, stop, unknown codes: the sequencer goes straight to the emit
//   state. Start and reset first pass the load state, which copies the reload value into the count.
//   Tick: the shared decrementer walks the allocated timers one at a time
//   (memory read, then decrement, compare and write back), then the results
//   are loaded in turn. Every request keeps req_stall high until its last
//   result is loaded.
//   Reset clears the timers' enable, mode and allocation state, the tick
//   counter and the output valid flag; count and reload read as zero until
//   first written.
//   While rsp_stall is high with a result valid, the output register holds it
//   and the sequencer waits before loading the next one.
`default_nettype none

module software_timer_bank #(
   parameter int TIMERS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [2:0]  req_timer_index,
   input  wire logic [31:0] req_period,
   input  wire logic        req_one_shot,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_expired_valid,
   output logic [2:0]       rsp_expired_index,
   output logic             rsp_last_result,
   output logic [2:0]       rsp_handle,
   output logic             rsp_handle_valid,
   output logic [31:0]      rsp_tick_count
);

   localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CW = $clog2(TIMERS + 1);

   stb_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  walk_ff, walk_in;
   logic [CW-1:0]  alloc_ff, alloc_in;
   logic [31:0]    tick_ff, tick_in;
   logic [stb_pkg::HIT_CW-1:0] hit_cnt_ff, hit_cnt_in;
   logic [stb_pkg::HIT_AW-1:0] emit_ff, emit_in;
   logic [2:0]     hits_ff [stb_pkg::MAX_RESULTS];
   logic           hit_we;
   logic [2:0]     hit_wd;
   logic [2:0]     handle_ff, handle_in;
   logic           handle_vld_ff, handle_vld_in;
   logic [TIMERS-1:0] enabled_ff, enabled_in;
   logic [TIMERS-1:0] oneshot_ff, oneshot_in;
   logic [TIMERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [TIMERS-1:0] rl_vld_ff, rl_vld_in;

   logic [31:0]    count_mem_ff  [TIMERS];
   logic [31:0]    reload_mem_ff [TIMERS];
   logic [31:0]    count_rd_ff, reload_rd_ff;
   logic [AW-1:0]  rd_addr, rd_addr_ff;
   logic           cnt_we, rl_we;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    cnt_wd, rl_wd;

   logic [31:0]    count_val, reload_val, dec_val;
   logic           req_xfer, out_free, idx_ok, emit_last;
   logic           load_out;
   logic           start_op_ff, start_op_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ev_ff;
   logic [2:0]     rsp_ei_ff;
   logic           rsp_last_ff;
   logic [2:0]     rsp_handle_ff;
   logic           rsp_hv_ff;
   logic [31:0]    rsp_tick_ff;

   assign req_stall = (state_ff != stb_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_ok    = (32'(req_timer_index) < TIMERS);
   assign rd_addr   = (state_ff == stb_pkg::ST_IDLE) ? AW'(req_timer_index)
                                                      : walk_ff[AW-1:0];
   assign count_val  = cnt_vld_ff[rd_addr_ff] ? count_rd_ff : 32'd0;
   assign reload_val = rl_vld_ff[rd_addr_ff] ? reload_rd_ff : 32'd0;
   assign dec_val    = count_val - 32'd1;
   assign emit_last  = (hit_cnt_ff == '0) ||
                       ({1'b0, emit_ff} == (hit_cnt_ff - stb_pkg::HIT_CW'(1)));

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      alloc_in      = alloc_ff;
      tick_in       = tick_ff;
      hit_cnt_in    = hit_cnt_ff;
      emit_in       = emit_ff;
      handle_in     = handle_ff;
      handle_vld_in = handle_vld_ff;
      enabled_in    = enabled_ff;
      oneshot_in    = oneshot_ff;
      cnt_vld_in    = cnt_vld_ff;
      rl_vld_in     = rl_vld_ff;
      start_op_in   = start_op_ff;
      hit_we        = 1'b0;
      hit_wd        = 3'(rd_addr_ff);
      cnt_we        = 1'b0;
      rl_we         = 1'b0;
      wr_addr       = rd_addr_ff;
      cnt_wd        = reload_val;
      rl_wd         = req_period;
      load_out      = 1'b0;
      unique case (state_ff)
         stb_pkg::ST_IDLE: begin
            if (req_xfer) begin
               hit_cnt_in    = '0;
               emit_in       = '0;
               handle_in     = 3'd0;
               handle_vld_in = 1'b0;
               state_in      = stb_pkg::ST_EMIT;
               wr_addr       = AW'(req_timer_index);
               case (req_type)
                  stb_pkg::REQ_TICK: begin
                     tick_in = tick_ff + 32'd1;
                     walk_in = '0;
                     if (alloc_ff != '0) begin
                        state_in = stb_pkg::ST_WALK_RD;
                     end
                  end
                  stb_pkg::REQ_ALLOC: begin
                     if (alloc_ff < CW'(TIMERS)) begin
                        handle_in     = 3'(alloc_ff);
                        handle_vld_in = 1'b1;
                        alloc_in      = alloc_ff + CW'(1);
                     end
                  end
                  stb_pkg::REQ_SET: begin
                     if (idx_ok) begin
                        cnt_we                = 1'b1;
                        rl_we                 = 1'b1;
                        cnt_wd                = req_period;
                        cnt_vld_in[wr_addr]   = 1'b1;
                        rl_vld_in[wr_addr]    = 1'b1;
                        oneshot_in[wr_addr]   = req_one_shot;
                     end
                  end
                  stb_pkg::REQ_START, stb_pkg::REQ_RESET: begin
                     if (idx_ok) begin
                        start_op_in = (req_type == stb_pkg::REQ_START);
                        state_in    = stb_pkg::ST_LOAD;
                     end
                  end
                  stb_pkg::REQ_STOP: begin
                     if (idx_ok) begin
                        enabled_in[wr_addr] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         stb_pkg::ST_LOAD: begin
            cnt_we                 = 1'b1;
            cnt_vld_in[rd_addr_ff] = 1'b1;
            enabled_in[rd_addr_ff] = start_op_ff;
            state_in               = stb_pkg::ST_EMIT;
         end
         stb_pkg::ST_WALK_RD: begin
            state_in = stb_pkg::ST_WALK_UPD;
         end
         stb_pkg::ST_WALK_UPD: begin
            if (enabled_ff[rd_addr_ff]) begin
               cnt_we                 = 1'b1;
               cnt_vld_in[rd_addr_ff] = 1'b1;
               if (dec_val == 32'd0) begin
                  if (oneshot_ff[rd_addr_ff]) begin
                     enabled_in[rd_addr_ff] = 1'b0;
                  end
                  if (hit_cnt_ff < stb_pkg::HIT_CW'(stb_pkg::MAX_RESULTS)) begin
                     hit_we     = 1'b1;
                     hit_cnt_in = hit_cnt_ff + stb_pkg::HIT_CW'(1);
                  end
               end else begin
                  cnt_wd = dec_val;
               end
            end
            walk_in = walk_ff + CW'(1);
            if ((walk_ff + CW'(1)) == alloc_ff) begin
               state_in = stb_pkg::ST_EMIT;
            end else begin
               state_in = stb_pkg::ST_WALK_RD;
            end
         end
         stb_pkg::ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               emit_in  = emit_ff + stb_pkg::HIT_AW'(1);
               if (emit_last) begin
                  state_in = stb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = stb_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stb_pkg::ST_IDLE;
         walk_ff       <= '0;
         alloc_ff      <= '0;
         tick_ff       <= '0;
         hit_cnt_ff    <= '0;
         emit_ff       <= '0;
         handle_ff     <= '0;
         handle_vld_ff <= 1'b0;
         enabled_ff    <= '0;
         oneshot_ff    <= '0;
         cnt_vld_ff    <= '0;
         rl_vld_ff     <= '0;
         start_op_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         alloc_ff      <= alloc_in;
         tick_ff       <= tick_in;
         hit_cnt_ff    <= hit_cnt_in;
         emit_ff       <= emit_in;
         handle_ff     <= handle_in;
         handle_vld_ff <= handle_vld_in;
         enabled_ff    <= enabled_in;
         oneshot_ff    <= oneshot_in;
         cnt_vld_ff    <= cnt_vld_in;
         rl_vld_ff     <= rl_vld_in;
         start_op_ff   <= start_op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_we) begin
         hits_ff[hit_cnt_ff[stb_pkg::HIT_AW-1:0]] <= hit_wd;
      end
      if (load_out) begin
         rsp_ev_ff     <= (hit_cnt_ff != '0);
         rsp_ei_ff     <= (hit_cnt_ff != '0) ? hits_ff[emit_ff] : 3'd0;
         rsp_last_ff   <= emit_last;
         rsp_handle_ff <= handle_ff;
         rsp_hv_ff     <= handle_vld_ff;
         rsp_tick_ff   <= tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem_ff[wr_addr] <= cnt_wd;
      end
      if (rl_we) begin
         reload_mem_ff[wr_addr] <= rl_wd;
      end
      count_rd_ff  <= count_mem_ff[rd_addr];
      reload_rd_ff <= reload_mem_ff[rd_addr];
      rd_addr_ff   <= rd_addr;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired_valid = rsp_ev_ff;
   assign rsp_expired_index = rsp_ei_ff;
   assign rsp_last_result   = rsp_last_ff;
   assign rsp_handle        = rsp_handle_ff;
   assign rsp_handle_valid  = rsp_hv_ff;
   assign rsp_tick_count    = rsp_tick_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != stb_pkg::ST_IDLE))
      else $error("request transfer did not start the sequencer");

   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= stb_pkg::HIT_CW'(stb_pkg::MAX_RESULTS))
      else $error("expiry list overflow");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= CW'(TIMERS))
      else $error("allocation count beyond bank size");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stb_pkg::ST_WALK_RD || state_ff == stb_pkg::ST_WALK_UPD)
      |-> (walk_ff < alloc_ff))
      else $error("walk past allocated timers");

   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ev_ff) |-> rsp_last_ff)
      else $error("non-expiry result not marked last");

endmodule

`default_nettype wire
